// ----- rtl/dzt_pkg.sv -----
// ----------------------------------------------------------------------------
// dzt_pkg
// Shared types and constants for the deadzone view tracker.
// ----------------------------------------------------------------------------
package dzt_pkg;

    localparam int PT_W      = 32;   // coordinate field width, Q24.8
    localparam int DZ_W      = 31;   // deadzone register width
    localparam int GAIN_W    = 17;   // step gain width, Q1.16 unsigned
    localparam int GAIN_FRAC = 16;   // fraction bits of the gain
    localparam int FMODE_W   = 2;    // follow mode width
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    // item mode codes
    localparam logic MODE_FOLLOW = 1'b0;
    localparam logic MODE_FORCE  = 1'b1;

    // follow mode bit positions
    localparam int FM_LOCK_X  = 0;
    localparam int FM_CEILING = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_X     = 3'd0,
        CFG_MAX_X     = 3'd1,
        CFG_MIN_Y     = 3'd2,
        CFG_MAX_Y     = 3'd3,
        CFG_DZ_X      = 3'd4,
        CFG_DZ_Y      = 3'd5,
        CFG_CEIL_Y    = 3'd6,
        CFG_FOLLOW    = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic signed [PT_W-1:0] min_center_x;
        logic signed [PT_W-1:0] max_center_x;
        logic signed [PT_W-1:0] min_center_y;
        logic signed [PT_W-1:0] max_center_y;
        logic [DZ_W-1:0]        deadzone_x;
        logic [DZ_W-1:0]        deadzone_y;
        logic signed [PT_W-1:0] ceiling_target_y;
        logic [FMODE_W-1:0]     follow_mode;
    } t_cfg;

    typedef struct packed {
        logic                   mode;
        logic signed [PT_W-1:0] point_x;
        logic signed [PT_W-1:0] point_y;
        logic [GAIN_W-1:0]      step_gain;
    } t_item;

    typedef struct packed {
        logic signed [PT_W-1:0] center_x;
        logic signed [PT_W-1:0] center_y;
    } t_result;

endpackage

// ----- rtl/dzt_in_if.sv -----
// ----------------------------------------------------------------------------
// dzt_in_if
// Input channel: one tracking or force word per handshake.
// ----------------------------------------------------------------------------
interface dzt_in_if;
    import dzt_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   mode;
    logic signed [PT_W-1:0] point_x;
    logic signed [PT_W-1:0] point_y;
    logic [GAIN_W-1:0]      step_gain;

    modport source (output valid, output mode, output point_x, output point_y,
                    output step_gain, input ready);
    modport sink   (input valid, input mode, input point_x, input point_y,
                    input step_gain, output ready);
endinterface

// ----- rtl/dzt_out_if.sv -----
// ----------------------------------------------------------------------------
// dzt_out_if
// Output channel: one view centre word per handshake.
// ----------------------------------------------------------------------------
interface dzt_out_if;
    import dzt_pkg::*;

    logic                   valid;
    logic                   ready;
    logic signed [PT_W-1:0] center_x;
    logic signed [PT_W-1:0] center_y;

    modport source (output valid, output center_x, output center_y, input ready);
    modport sink   (input valid, input center_x, input center_y, output ready);
endinterface

// ----- rtl/dzt_cfg.sv -----
// ----------------------------------------------------------------------------
// dzt_cfg
// Configuration register file, write only.
// ----------------------------------------------------------------------------
module dzt_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_we,
    input  logic [dzt_pkg::CFG_IDX_W-1:0]  i_idx,
    input  logic [dzt_pkg::CFG_DAT_W-1:0]  i_data,
    output dzt_pkg::t_cfg                  o_cfg
);
    import dzt_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_we) begin
            unique case (t_cfg_idx'(i_idx))
                CFG_MIN_X:  r_cfg.min_center_x     <= i_data[PT_W-1:0];
                CFG_MAX_X:  r_cfg.max_center_x     <= i_data[PT_W-1:0];
                CFG_MIN_Y:  r_cfg.min_center_y     <= i_data[PT_W-1:0];
                CFG_MAX_Y:  r_cfg.max_center_y     <= i_data[PT_W-1:0];
                CFG_DZ_X:   r_cfg.deadzone_x       <= i_data[DZ_W-1:0];
                CFG_DZ_Y:   r_cfg.deadzone_y       <= i_data[DZ_W-1:0];
                CFG_CEIL_Y: r_cfg.ceiling_target_y <= i_data[PT_W-1:0];
                CFG_FOLLOW: r_cfg.follow_mode      <= i_data[FMODE_W-1:0];
                default:    r_cfg                  <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/dzt_axis.sv -----
// ----------------------------------------------------------------------------
// dzt_axis
// One axis step: goal pick, gain lerp with rounding, clamp, force or pin select, saturate.
// ----------------------------------------------------------------------------
module dzt_axis #(
    parameter int W = 32
) (
    input  logic signed [W-1:0]                 i_cur,
    input  logic signed [dzt_pkg::PT_W-1:0]     i_point,
    input  logic [dzt_pkg::DZ_W-1:0]            i_deadzone,
    input  logic                                i_direct,   // use i_goal as target
    input  logic signed [dzt_pkg::PT_W-1:0]     i_goal,
    input  logic [dzt_pkg::GAIN_W-1:0]          i_gain,
    input  logic signed [dzt_pkg::PT_W-1:0]     i_lo,
    input  logic signed [dzt_pkg::PT_W-1:0]     i_hi,
    input  logic                                i_pin,      // pin to lower limit
    input  logic                                i_force,    // load point as is
    output logic signed [W-1:0]                 o_next
);
    import dzt_pkg::*;

    localparam int SW = (W > PT_W) ? W : PT_W;
    localparam int XW = SW + 2;
    localparam int PW = XW + GAIN_W + 1;
    localparam logic signed [PW-1:0] ROUND  = PW'(1) <<< (GAIN_FRAC - 1);
    localparam logic signed [PW-1:0] SAT_HI = {{(PW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [PW-1:0] SAT_LO = ~SAT_HI;

    logic signed [XW-1:0] w_cur, w_pt, w_dz, w_goal, w_diff;
    logic signed [PW-1:0] w_prod, w_step, w_app, w_lo, w_hi, w_clamp, w_sel, w_sat;

    always_comb begin
        w_cur = XW'(i_cur);
        w_pt  = XW'(i_point);
        w_dz  = XW'($signed({1'b0, i_deadzone}));

        if (i_direct) begin
            w_goal = XW'(i_goal);
        end else if (w_pt > w_cur + w_dz) begin
            w_goal = w_pt - w_dz;
        end else if (w_pt < w_cur - w_dz) begin
            w_goal = w_pt + w_dz;
        end else begin
            w_goal = w_cur;
        end

        w_diff = w_goal - w_cur;
        w_prod = PW'(w_diff) * PW'($signed({1'b0, i_gain}));
        // round to nearest, ties up: floor((p + half) / 2^16)
        w_step = (w_prod + ROUND) >>> GAIN_FRAC;
        w_app  = w_step + PW'(w_cur);

        w_lo = PW'(i_lo);
        w_hi = (PW'(i_hi) < w_lo) ? w_lo : PW'(i_hi);
        if (w_app < w_lo) begin
            w_clamp = w_lo;
        end else if (w_app > w_hi) begin
            w_clamp = w_hi;
        end else begin
            w_clamp = w_app;
        end

        if (i_force) begin
            w_sel = PW'(w_pt);
        end else if (i_pin) begin
            w_sel = w_lo;
        end else begin
            w_sel = w_clamp;
        end

        if (w_sel > SAT_HI) begin
            w_sat = SAT_HI;
        end else if (w_sel < SAT_LO) begin
            w_sat = SAT_LO;
        end else begin
            w_sat = w_sel;
        end
    end

    assign o_next = w_sat[W-1:0];

endmodule

// ----- rtl/deadzone_smoothed_view_tracker_unit.sv -----
// ----------------------------------------------------------------------------
// deadzone_smoothed_view_tracker_unit
// Deadzone follow camera: smoothed approach of the view centre, with limits.
// ----------------------------------------------------------------------------
// Path: the input word is registered in s1, then the result in the result
//   register; a stalled output holds the word in s1.
// Throughput: one word per cycle unless the output stalls; the stored centre
//   feeds the next word directly, through one gain multiply and clamp per axis.
// Reset (synchronous, i_rst_n low): config registers and view centre go to
//   zero, both stages empty.
// ----------------------------------------------------------------------------
module deadzone_smoothed_view_tracker_unit #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [dzt_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [dzt_pkg::CFG_DAT_W-1:0]  i_cfg_data,
    dzt_in_if.sink                         i_in,
    dzt_out_if.source                      o_out
);
    import dzt_pkg::*;

    localparam int SW = (COORD_WIDTH > PT_W) ? COORD_WIDTH : PT_W;

    // config
    t_cfg w_cfg;

    dzt_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    // input stage
    logic  r_s1_valid;
    t_item r_s1;
    // result stage
    logic    r_out_valid;
    t_result r_out;
    // view centre state
    logic signed [COORD_WIDTH-1:0] r_cx, r_cy;
    logic signed [COORD_WIDTH-1:0] n_cx, n_cy;

    logic w_s1_adv, w_in_ready, w_in_take;
    logic w_force, w_lock_x, w_ceiling;
    logic signed [SW-1:0] w_cx_ext, w_cy_ext;
    logic signed [SW-1:0] w_nx_ext, w_ny_ext;

    // s1 moves into the result register when that is free or being drained
    assign w_s1_adv   = r_s1_valid && (!r_out_valid || o_out.ready);
    // s1 takes a new word when empty or when its word leaves this cycle
    assign w_in_ready = !r_s1_valid || w_s1_adv;
    assign w_in_take  = i_in.valid && w_in_ready;

    assign w_force   = (r_s1.mode == MODE_FORCE);
    assign w_lock_x  = w_cfg.follow_mode[FM_LOCK_X];
    assign w_ceiling = w_cfg.follow_mode[FM_CEILING];

    // X: ceiling mode heads straight for the point; lock pins to min limit
    dzt_axis #(.W(COORD_WIDTH)) u_axis_x (
        .i_cur      (r_cx),
        .i_point    (r_s1.point_x),
        .i_deadzone (w_cfg.deadzone_x),
        .i_direct   (w_ceiling),
        .i_goal     (r_s1.point_x),
        .i_gain     (r_s1.step_gain),
        .i_lo       (w_cfg.min_center_x),
        .i_hi       (w_cfg.max_center_x),
        .i_pin      (w_lock_x),
        .i_force    (w_force),
        .o_next     (n_cx)
    );

    // Y: ceiling mode heads for the fixed target
    dzt_axis #(.W(COORD_WIDTH)) u_axis_y (
        .i_cur      (r_cy),
        .i_point    (r_s1.point_y),
        .i_deadzone (w_cfg.deadzone_y),
        .i_direct   (w_ceiling),
        .i_goal     (w_cfg.ceiling_target_y),
        .i_gain     (r_s1.step_gain),
        .i_lo       (w_cfg.min_center_y),
        .i_hi       (w_cfg.max_center_y),
        .i_pin      (1'b0),
        .i_force    (w_force),
        .o_next     (n_cy)
    );

    // low 32 bits of the centre, sign extended first for narrow coordinates
    assign w_nx_ext = SW'(n_cx);
    assign w_ny_ext = SW'(n_cy);
    assign w_cx_ext = SW'(r_cx);
    assign w_cy_ext = SW'(r_cy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_cx        <= '0;
            r_cy        <= '0;
        end else begin
            if (w_in_ready) begin
                r_s1_valid <= i_in.valid;
            end
            if (w_s1_adv) begin
                r_out_valid <= 1'b1;
                r_cx        <= n_cx;
                r_cy        <= n_cy;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_s1.mode      <= i_in.mode;
            r_s1.point_x   <= i_in.point_x;
            r_s1.point_y   <= i_in.point_y;
            r_s1.step_gain <= i_in.step_gain;
        end
        if (w_s1_adv) begin
            r_out.center_x <= w_nx_ext[PT_W-1:0];
            r_out.center_y <= w_ny_ext[PT_W-1:0];
        end
    end

    assign i_in.ready     = w_in_ready;
    assign o_out.valid    = r_out_valid;
    assign o_out.center_x = r_out.center_x;
    assign o_out.center_y = r_out.center_y;

`ifndef ASSERT_OFF
    // a held word in s1 is not dropped
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !w_s1_adv |=> r_s1_valid)
        else $error("s1 word lost while stalled");

    // every advance leaves a result waiting
    a_adv_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s1_adv |=> r_out_valid)
        else $error("advance without result");

    // a pending result always mirrors the stored centre
    a_out_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.center_x == w_cx_ext[PT_W-1:0]) &&
                        (r_out.center_y == w_cy_ext[PT_W-1:0]))
        else $error("result differs from stored centre");

    // input back-pressure only with a word stuck in s1
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_in_ready |-> r_s1_valid && r_out_valid && !o_out.ready)
        else $error("ready low without a stall");
`endif

endmodule
